/* design/gaa_pkg.sv */
// Shared constants and the sequencer state type for the gravity accumulator.
`timescale 1ns / 1ps

package gaa_pkg;

    // Default widths handed to the top level
    localparam int COORD_WIDTH_DEF = 32;
    localparam int ACCEL_WIDTH_DEF = 48;

    // Gravity constant after reset: 1.0 in Q16.16
    localparam logic [31:0] GRAV_RESET = 32'h0001_0000;

    // Fixed operand widths
    localparam int OPW   = 32;   // gravity, mass, min distance
    localparam int KW    = 64;   // gravity * mass
    localparam int QW    = 128;  // quotient and denominator
    localparam int FRACW = 32;   // fraction bits dropped after the axis product

    // Sequencer states, one-hot
    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_SQX  = 12'b0000_0000_0010,
        S_SQY  = 12'b0000_0000_0100,
        S_SQM  = 12'b0000_0000_1000,
        S_SQRT = 12'b0000_0001_0000,
        S_MK   = 12'b0000_0010_0000,
        S_D2M  = 12'b0000_0100_0000,
        S_D3   = 12'b0000_1000_0000,
        S_DIV  = 12'b0001_0000_0000,
        S_MX   = 12'b0010_0000_0000,
        S_MY   = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } t_state;

endpackage

/* design/gravity_accel_accumulator_core.sv */
// Softened gravity acceleration accumulator: sequencer around one shared adder.
`timescale 1ns / 1ps

// Channel   | Direction | Handshake                 | Word
// ----------+-----------+---------------------------+--------------------------------------
// input     | in        | i_in_valid / o_in_stall   | target, source, mass, min dist, last
// output    | out       | o_out_valid / i_out_stall | accel_x, accel_y, saturated
// config    | in        | i_cfg_we                  | i_cfg_data (gravity constant)
//
// Every product is a shift-add over the shared adder that ends once the multiplier's
// remaining bits are zero. The square root takes one result bit a cycle and the
// 128-bit divide one quotient bit a cycle; the divide's 128 steps dominate.
// A coincident source on a non-last word adds nothing and the sequencer stays idle.
// Reset is synchronous, active low; it clears the sums and flag and sets the gravity constant to 1.0.
// The input is stalled from acceptance until the word is done or its result taken.
// A result holds on the output while i_out_stall is high.

module gravity_accel_accumulator_core #(
    parameter int COORD_WIDTH = gaa_pkg::COORD_WIDTH_DEF,
    parameter int ACCEL_WIDTH = gaa_pkg::ACCEL_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [gaa_pkg::OPW-1:0]       i_cfg_data,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic signed [COORD_WIDTH-1:0] i_source_x,
    input  logic signed [COORD_WIDTH-1:0] i_source_y,
    input  logic [gaa_pkg::OPW-1:0]       i_source_mass,
    input  logic [gaa_pkg::OPW-1:0]       i_min_distance,
    input  logic                          i_last_source,
    // output channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [ACCEL_WIDTH-1:0] o_accel_x,
    output logic signed [ACCEL_WIDTH-1:0] o_accel_y,
    output logic                          o_saturated
);

    localparam int DW   = COORD_WIDTH + 1;                      // |dx| bits
    localparam int D2W  = (2 * DW + 1 > 2 * gaa_pkg::OPW) ? 2 * DW + 1 : 2 * gaa_pkg::OPW;
    localparam int RW   = (D2W + 1) / 2;                        // distance bits
    localparam int AW   = gaa_pkg::QW + DW;                     // accumulator bits
    localparam int LW   = AW + 1;                               // adder bits
    localparam int CNTW = $clog2(gaa_pkg::QW + 1);
    localparam int MHI  = gaa_pkg::FRACW + ACCEL_WIDTH - 2;     // top kept product bit

    localparam logic [ACCEL_WIDTH-2:0] AMAX    = '1;
    localparam logic [ACCEL_WIDTH-1:0] SUM_MAX = {1'b0, AMAX};
    localparam logic [ACCEL_WIDTH-1:0] SUM_MIN = {1'b1, {(ACCEL_WIDTH-1){1'b0}}};

    // control registers
    gaa_pkg::t_state         r_state, n_state;
    logic [CNTW-1:0]         r_cnt, n_cnt;
    logic [gaa_pkg::OPW-1:0] r_gconst, n_gconst;
    logic [ACCEL_WIDTH-1:0]  r_sum_x, n_sum_x, r_sum_y, n_sum_y;
    logic                    r_clip, n_clip;
    logic                    r_last, n_last;

    // datapath registers
    logic [AW-1:0]           r_ma, n_ma, r_acc, n_acc;
    logic [RW-1:0]           r_mb, n_mb, r_dist, n_dist;
    logic [gaa_pkg::OPW-1:0] r_mass, n_mass, r_mind, n_mind;
    logic [DW-1:0]           r_ax, n_ax, r_ay, n_ay;
    logic                    r_negx, n_negx, r_negy, n_negy;
    logic [D2W-1:0]          r_d2, n_d2;
    logic [gaa_pkg::KW-1:0]  r_k, n_k;
    logic [gaa_pkg::QW-1:0]  r_den, n_den, r_q, n_q;

    // shared adder / subtractor
    logic [LW-1:0] alu_a, alu_b, alu_res;
    logic          alu_sub;
    assign alu_res = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    // input differences
    logic signed [DW-1:0] dx_in, dy_in;
    logic [DW-1:0]        ax_in, ay_in;
    assign dx_in = $signed({i_source_x[COORD_WIDTH-1], i_source_x})
                 - $signed({i_target_x[COORD_WIDTH-1], i_target_x});
    assign dy_in = $signed({i_source_y[COORD_WIDTH-1], i_source_y})
                 - $signed({i_target_y[COORD_WIDTH-1], i_target_y});
    assign ax_in = dx_in[DW-1] ? DW'(-dx_in) : DW'(dx_in);
    assign ay_in = dy_in[DW-1] ? DW'(-dy_in) : DW'(dy_in);

    // axis term from the finished product and saturating add
    logic                   term_clip, term_neg, sum_ovf;
    logic [ACCEL_WIDTH-2:0] mag;
    logic [ACCEL_WIDTH-1:0] mag_ext, term, sum_sel, sat_res;
    logic [ACCEL_WIDTH:0]   sum_ext;
    assign term_clip = |r_acc[AW-1:MHI+1];
    assign mag       = term_clip ? AMAX : r_acc[MHI:gaa_pkg::FRACW];
    assign mag_ext   = {1'b0, mag};
    assign term_neg  = (r_state == gaa_pkg::S_MY) ? r_negy : r_negx;
    assign term      = term_neg ? (~mag_ext + 1'b1) : mag_ext;
    assign sum_sel   = (r_state == gaa_pkg::S_MY) ? r_sum_y : r_sum_x;
    assign sum_ext   = {sum_sel[ACCEL_WIDTH-1], sum_sel} + {term[ACCEL_WIDTH-1], term};
    assign sum_ovf   = sum_ext[ACCEL_WIDTH] != sum_ext[ACCEL_WIDTH-1];
    assign sat_res   = sum_ovf ? (sum_ext[ACCEL_WIDTH] ? SUM_MIN : SUM_MAX)
                               : sum_ext[ACCEL_WIDTH-1:0];

    // root / divide step helpers
    logic [AW-1:0]         rem_sh;
    logic                  ge;
    logic [gaa_pkg::QW-1:0] q_next;
    logic [RW-1:0]         root_next;
    assign ge        = ~alu_res[LW-1];
    assign q_next    = {r_q[gaa_pkg::QW-2:0], ge};
    assign root_next = {r_mb[RW-2:0], ge};

    // sequencer and datapath next values
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_gconst = i_cfg_we ? i_cfg_data : r_gconst;
        n_sum_x  = r_sum_x;
        n_sum_y  = r_sum_y;
        n_clip   = r_clip;
        n_last   = r_last;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_acc    = r_acc;
        n_dist   = r_dist;
        n_mass   = r_mass;
        n_mind   = r_mind;
        n_ax     = r_ax;
        n_ay     = r_ay;
        n_negx   = r_negx;
        n_negy   = r_negy;
        n_d2     = r_d2;
        n_k      = r_k;
        n_den    = r_den;
        n_q      = r_q;
        rem_sh   = '0;
        alu_a    = LW'(r_acc);
        alu_b    = LW'(r_ma);
        alu_sub  = 1'b0;

        unique case (r_state)
            gaa_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_ax   = ax_in;
                    n_ay   = ay_in;
                    n_negx = dx_in[DW-1];
                    n_negy = dy_in[DW-1];
                    n_mass = i_source_mass;
                    n_mind = i_min_distance;
                    n_last = i_last_source;
                    if (ax_in == '0 && ay_in == '0) begin
                        // coincident source adds nothing
                        if (i_last_source) n_state = gaa_pkg::S_OUT;
                    end else begin
                        n_acc   = '0;
                        n_ma    = AW'(ax_in);
                        n_mb    = RW'(ax_in);
                        n_state = gaa_pkg::S_SQX;
                    end
                end
            end
            gaa_pkg::S_SQX: begin
                if (r_mb == '0) begin
                    // keep ax^2 in the accumulator and add ay^2 on top
                    n_ma    = AW'(r_ay);
                    n_mb    = RW'(r_ay);
                    n_state = gaa_pkg::S_SQY;
                end else begin
                    if (r_mb[0]) n_acc = alu_res[AW-1:0];
                    n_ma = {r_ma[AW-2:0], 1'b0};
                    n_mb = r_mb >> 1;
                end
            end
            gaa_pkg::S_SQY: begin
                if (r_mb == '0) begin
                    n_d2    = r_acc[D2W-1:0];
                    n_acc   = '0;
                    n_ma    = AW'(r_mind);
                    n_mb    = RW'(r_mind);
                    n_state = gaa_pkg::S_SQM;
                end else begin
                    if (r_mb[0]) n_acc = alu_res[AW-1:0];
                    n_ma = {r_ma[AW-2:0], 1'b0};
                    n_mb = r_mb >> 1;
                end
            end
            gaa_pkg::S_SQM: begin
                if (r_mb == '0) begin
                    // clamp to min distance squared, then start the root
                    n_ma    = (r_d2 < r_acc[D2W-1:0]) ? AW'(r_acc[D2W-1:0]) : AW'(r_d2);
                    n_acc   = '0;
                    n_mb    = '0;
                    n_cnt   = CNTW'(RW);
                    n_state = gaa_pkg::S_SQRT;
                end else begin
                    if (r_mb[0]) n_acc = alu_res[AW-1:0];
                    n_ma = {r_ma[AW-2:0], 1'b0};
                    n_mb = r_mb >> 1;
                end
            end
            gaa_pkg::S_SQRT: begin
                // one root bit per cycle: remainder in acc, radicand in ma, root in mb
                rem_sh  = {r_acc[AW-3:0], r_ma[2*RW-1 -: 2]};
                alu_a   = LW'(rem_sh);
                alu_b   = LW'({r_mb, 2'b01});
                alu_sub = 1'b1;
                n_acc   = ge ? alu_res[AW-1:0] : rem_sh;
                n_mb    = root_next;
                n_ma    = {r_ma[AW-3:0], 2'b00};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    n_dist  = root_next;
                    n_acc   = '0;
                    n_ma    = AW'(r_gconst);
                    n_mb    = RW'(r_mass);
                    n_state = gaa_pkg::S_MK;
                end
            end
            gaa_pkg::S_MK: begin
                if (r_mb == '0) begin
                    n_k     = r_acc[gaa_pkg::KW-1:0];
                    n_acc   = '0;
                    n_ma    = AW'(r_dist);
                    n_mb    = r_dist;
                    n_state = gaa_pkg::S_D2M;
                end else begin
                    if (r_mb[0]) n_acc = alu_res[AW-1:0];
                    n_ma = {r_ma[AW-2:0], 1'b0};
                    n_mb = r_mb >> 1;
                end
            end
            gaa_pkg::S_D2M: begin
                if (r_mb == '0) begin
                    n_ma    = r_acc;
                    n_acc   = '0;
                    n_mb    = r_dist;
                    n_state = gaa_pkg::S_D3;
                end else begin
                    if (r_mb[0]) n_acc = alu_res[AW-1:0];
                    n_ma = {r_ma[AW-2:0], 1'b0};
                    n_mb = r_mb >> 1;
                end
            end
            gaa_pkg::S_D3: begin
                if (r_mb == '0) begin
                    if (|r_acc[AW-1:gaa_pkg::QW]) begin
                        // distance cubed beyond 128 bits: quotient is zero
                        n_q     = '0;
                        n_acc   = '0;
                        n_ma    = '0;
                        n_mb    = RW'(r_ax);
                        n_state = gaa_pkg::S_MX;
                    end else begin
                        n_den   = r_acc[gaa_pkg::QW-1:0];
                        n_ma    = AW'({r_k, {gaa_pkg::KW{1'b0}}});
                        n_acc   = '0;
                        n_cnt   = CNTW'(gaa_pkg::QW);
                        n_state = gaa_pkg::S_DIV;
                    end
                end else begin
                    if (r_mb[0]) n_acc = alu_res[AW-1:0];
                    n_ma = {r_ma[AW-2:0], 1'b0};
                    n_mb = r_mb >> 1;
                end
            end
            gaa_pkg::S_DIV: begin
                // restoring divide, one quotient bit per cycle
                rem_sh  = {r_acc[AW-2:0], r_ma[gaa_pkg::QW-1]};
                alu_a   = LW'(rem_sh);
                alu_b   = LW'(r_den);
                alu_sub = 1'b1;
                n_acc   = ge ? alu_res[AW-1:0] : rem_sh;
                n_q     = q_next;
                n_ma    = {r_ma[AW-2:0], 1'b0};
                n_cnt   = r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    n_acc   = '0;
                    n_ma    = AW'(q_next);
                    n_mb    = RW'(r_ax);
                    n_state = gaa_pkg::S_MX;
                end
            end
            gaa_pkg::S_MX: begin
                if (r_mb == '0) begin
                    n_sum_x = sat_res;
                    n_clip  = r_clip | term_clip | sum_ovf;
                    n_acc   = '0;
                    n_ma    = AW'(r_q);
                    n_mb    = RW'(r_ay);
                    n_state = gaa_pkg::S_MY;
                end else begin
                    if (r_mb[0]) n_acc = alu_res[AW-1:0];
                    n_ma = {r_ma[AW-2:0], 1'b0};
                    n_mb = r_mb >> 1;
                end
            end
            gaa_pkg::S_MY: begin
                if (r_mb == '0) begin
                    n_sum_y = sat_res;
                    n_clip  = r_clip | term_clip | sum_ovf;
                    n_state = r_last ? gaa_pkg::S_OUT : gaa_pkg::S_IDLE;
                end else begin
                    if (r_mb[0]) n_acc = alu_res[AW-1:0];
                    n_ma = {r_ma[AW-2:0], 1'b0};
                    n_mb = r_mb >> 1;
                end
            end
            gaa_pkg::S_OUT: begin
                // sums clear once the result word is taken
                if (!i_out_stall) begin
                    n_sum_x = '0;
                    n_sum_y = '0;
                    n_clip  = 1'b0;
                    n_state = gaa_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = gaa_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gaa_pkg::S_IDLE;
            r_cnt    <= '0;
            r_gconst <= gaa_pkg::GRAV_RESET;
            r_sum_x  <= '0;
            r_sum_y  <= '0;
            r_clip   <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_gconst <= n_gconst;
            r_sum_x  <= n_sum_x;
            r_sum_y  <= n_sum_y;
            r_clip   <= n_clip;
            r_last   <= n_last;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_ma   <= n_ma;
        r_mb   <= n_mb;
        r_acc  <= n_acc;
        r_dist <= n_dist;
        r_mass <= n_mass;
        r_mind <= n_mind;
        r_ax   <= n_ax;
        r_ay   <= n_ay;
        r_negx <= n_negx;
        r_negy <= n_negy;
        r_d2   <= n_d2;
        r_k    <= n_k;
        r_den  <= n_den;
        r_q    <= n_q;
    end

    // ports
    assign o_in_stall  = (r_state != gaa_pkg::S_IDLE);
    assign o_out_valid = (r_state == gaa_pkg::S_OUT);
    assign o_accel_x   = r_sum_x;
    assign o_accel_y   = r_sum_y;
    assign o_saturated = r_clip;

    // checks
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state not one-hot");

    a_idle_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> !o_out_valid)
        else $error("result shown while accepting words");

    a_clear_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) |=> (r_sum_x == '0 && r_sum_y == '0 && !r_clip))
        else $error("sums not cleared after result word");

    a_coincident_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_source_x == i_target_x
         && i_source_y == i_target_y && !i_last_source)
        |=> (!o_in_stall && $stable(r_sum_x) && $stable(r_sum_y)))
        else $error("coincident source changed the sums");

endmodule
